// ===== rtl/core/ami_pkg.sv =====
// Shared constants, register indexes and controller/datapath types for the inverse unit.
`default_nettype none

package ami_pkg;

  // Operand geometry
  localparam int unsigned FIELD_BITS = 256;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned NWORDS     = FIELD_BITS / WORD_W;
  localparam int unsigned CNT_W      = 10;
  localparam int unsigned HCNT_W     = 9;
  localparam int unsigned CFG_IDX_W  = 2;

  // Phase I iteration bound, as a count value
  localparam logic [CNT_W-1:0]  STEP_LIMIT = CNT_W'(2 * FIELD_BITS);
  localparam logic [CNT_W-1:0]  HALF_BASE  = CNT_W'(FIELD_BITS);

  // Modulus reset value: SM2 prime p
  localparam logic [FIELD_BITS-1:0] MODULUS_RESET = {
    64'hFFFF_FFFE_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF
  };

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_W0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_W1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_W2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_W3 = 2'd3;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_STEP,
    OP_REDUCE,
    OP_NEGATE,
    OP_HALVE,
    OP_PUBLISH
  } ami_op_e;

  typedef struct packed {
    ami_op_e op;
  } ami_cmd_t;

  typedef struct packed {
    logic v_zero;   // v has reached zero
    logic cnt_max;  // phase I step bound reached
    logic h_done;   // no halvings left
  } ami_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/ami_if.sv =====
// Valid/ready channel interfaces for operand and result beats.
`default_nettype none

interface ami_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_w0;
  logic [63:0] value_w1;
  logic [63:0] value_w2;
  logic [63:0] value_w3;

  modport source (output valid, output value_w0, output value_w1, output value_w2,
                  output value_w3, input ready);
  modport sink   (input valid, input value_w0, input value_w1, input value_w2,
                  input value_w3, output ready);
endinterface

interface ami_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] inverse_w0;
  logic [63:0] inverse_w1;
  logic [63:0] inverse_w2;
  logic [63:0] inverse_w3;
  logic [9:0]  almost_exponent;
  logic        zero_operand;

  modport source (output valid, output inverse_w0, output inverse_w1, output inverse_w2,
                  output inverse_w3, output almost_exponent, output zero_operand,
                  input ready);
  modport sink   (input valid, input inverse_w0, input inverse_w1, input inverse_w2,
                  input inverse_w3, input almost_exponent, input zero_operand,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ami_datapath.sv =====
// Datapath: modulus registers, u/v/r/s working registers, adders and result register.
`default_nettype none

module ami_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration writes
  input  wire logic                                cfg_we_i,
  input  wire logic [ami_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [ami_pkg::WORD_W-1:0]          cfg_data_i,
  // operand and control
  input  wire logic [ami_pkg::FIELD_BITS-1:0]      value_i,
  input  wire ami_pkg::ami_cmd_t                   cmd_i,
  output ami_pkg::ami_stat_t                       stat_o,
  // result payload
  output logic [ami_pkg::FIELD_BITS-1:0]           result_o,
  output logic [ami_pkg::CNT_W-1:0]                exponent_o,
  output logic                                     zero_o
);
  import ami_pkg::*;

  logic [FIELD_BITS-1:0] m_q;
  logic [FIELD_BITS-1:0] u_q, u_d, v_q, v_d, r_q, r_d, s_q, s_d;
  logic                  ov_q, ov_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [HCNT_W-1:0]     hcnt_q, hcnt_d;
  logic                  zero_q;
  logic [FIELD_BITS-1:0] res_q;
  logic [CNT_W-1:0]      exp_q;
  logic                  zf_q;

  logic [FIELD_BITS:0]   diff_uv, diff_vu, sum_rs, half_sum;
  logic [FIELD_BITS+1:0] red_diff;
  logic                  u_gt_v;

  // Modulus registers, written a word at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= MODULUS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODULUS_W0: m_q[0*WORD_W +: WORD_W] <= cfg_data_i;
        REG_MODULUS_W1: m_q[1*WORD_W +: WORD_W] <= cfg_data_i;
        REG_MODULUS_W2: m_q[2*WORD_W +: WORD_W] <= cfg_data_i;
        REG_MODULUS_W3: m_q[3*WORD_W +: WORD_W] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Parallel adders: u-v, v-u (borrow gives u > v), r+s
  assign diff_uv = {1'b0, u_q} - {1'b0, v_q};
  assign diff_vu = {1'b0, v_q} - {1'b0, u_q};
  assign sum_rs  = {1'b0, r_q} + {1'b0, s_q};
  assign u_gt_v  = diff_vu[FIELD_BITS];

  // 257-bit r against m; no borrow means r >= m
  assign red_diff = {1'b0, ov_q, r_q} - {2'b00, m_q};

  // Modular halving: add m when r is odd
  assign half_sum = {1'b0, r_q} + (r_q[0] ? {1'b0, m_q} : '0);

  // Next-state selection per operation
  always_comb begin
    u_d    = u_q;
    v_d    = v_q;
    r_d    = r_q;
    s_d    = s_q;
    ov_d   = ov_q;
    cnt_d  = cnt_q;
    hcnt_d = hcnt_q;
    case (cmd_i.op)
      OP_LOAD: begin
        u_d    = m_q;
        v_d    = value_i;
        r_d    = '0;
        s_d    = FIELD_BITS'(1);
        ov_d   = 1'b0;
        cnt_d  = '0;
      end
      OP_STEP: begin
        cnt_d = cnt_q + 1'b1;
        if (!u_q[0]) begin
          u_d = {1'b0, u_q[FIELD_BITS-1:1]};
          s_d = {s_q[FIELD_BITS-2:0], 1'b0};
        end else if (!v_q[0]) begin
          v_d  = {1'b0, v_q[FIELD_BITS-1:1]};
          ov_d = r_q[FIELD_BITS-1];
          r_d  = {r_q[FIELD_BITS-2:0], 1'b0};
        end else if (u_gt_v) begin
          u_d  = {1'b0, diff_uv[FIELD_BITS-1:1]};
          r_d  = sum_rs[FIELD_BITS-1:0];
          ov_d = ov_q ^ sum_rs[FIELD_BITS];
          s_d  = {s_q[FIELD_BITS-2:0], 1'b0};
        end else begin
          v_d  = {1'b0, diff_vu[FIELD_BITS-1:1]};
          s_d  = sum_rs[FIELD_BITS-1:0];
          ov_d = r_q[FIELD_BITS-1];
          r_d  = {r_q[FIELD_BITS-2:0], 1'b0};
        end
      end
      OP_REDUCE: begin
        if (!red_diff[FIELD_BITS+1]) begin
          r_d  = red_diff[FIELD_BITS-1:0];
          ov_d = 1'b0;
        end
      end
      OP_NEGATE: begin
        r_d    = m_q - r_q;
        hcnt_d = (cnt_q > HALF_BASE) ? HCNT_W'(cnt_q - HALF_BASE) : '0;
      end
      OP_HALVE: begin
        r_d    = half_sum[FIELD_BITS:1];
        hcnt_d = hcnt_q - 1'b1;
      end
      default: ;
    endcase
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    u_q    <= u_d;
    v_q    <= v_d;
    r_q    <= r_d;
    s_q    <= s_d;
    ov_q   <= ov_d;
    cnt_q  <= cnt_d;
    hcnt_q <= hcnt_d;
    if (cmd_i.op == OP_LOAD) begin
      zero_q <= (value_i == '0);
    end
  end

  // Result register, loaded when the controller publishes
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_PUBLISH) begin
      res_q <= zero_q ? '0 : r_q;
      exp_q <= cnt_q;
      zf_q  <= zero_q;
    end
  end

  assign stat_o.v_zero  = (v_q == '0);
  assign stat_o.cnt_max = (cnt_q == STEP_LIMIT);
  assign stat_o.h_done  = (hcnt_q == '0);

  assign result_o   = res_q;
  assign exponent_o = exp_q;
  assign zero_o     = zf_q;

endmodule

`default_nettype wire

// ===== rtl/core/ami_ctrl.sv =====
// Controller: sequences load, phase I steps, reduction, halvings and result hand-off.
`default_nettype none

module ami_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire ami_pkg::ami_stat_t stat_i,
  output ami_pkg::ami_cmd_t     cmd_o
);
  import ami_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_REDUCE,
    ST_NEGATE,
    ST_HALVE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Result register can take a new beat when empty or being drained
  assign out_free = !out_valid_q || out_ready_i;

  // Next state and command decode
  always_comb begin
    state_d     = state_q;
    cmd_o.op    = OP_NOP;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_STEP;
        end
      end
      ST_STEP: begin
        if (stat_i.v_zero || stat_i.cnt_max) begin
          state_d = ST_REDUCE;
        end else begin
          cmd_o.op = OP_STEP;
        end
      end
      ST_REDUCE: begin
        cmd_o.op = OP_REDUCE;
        state_d  = ST_NEGATE;
      end
      ST_NEGATE: begin
        cmd_o.op = OP_NEGATE;
        state_d  = ST_HALVE;
      end
      ST_HALVE: begin
        if (!stat_i.h_done) begin
          cmd_o.op = OP_HALVE;
        end else if (out_free) begin
          cmd_o.op    = OP_PUBLISH;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and output-valid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/almost_montgomery_inverse_256.sv =====
// Per operand: load, k phase I steps (at most 512, set by the almost-inverse loop),
// reduction, negation, h = max(k - 256, 0) halvings, then publish. A new operand
// is taken only after publish, which waits while the result register still holds
// an undrained beat; a finished result waits there while the next one is taken.
// Reset (async, active low) returns the controller to idle, clears the result
// valid flag and loads the modulus registers with the SM2 prime p.
`default_nettype none

module almost_montgomery_inverse_256 (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  ami_in_if.sink                                   in_i,
  ami_out_if.source                                out_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [ami_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [ami_pkg::WORD_W-1:0]          cfg_data_i
);
  import ami_pkg::*;

  ami_cmd_t              cmd;
  ami_stat_t             stat;
  logic [FIELD_BITS-1:0] value;
  logic [FIELD_BITS-1:0] result;
  logic [CNT_W-1:0]      exponent;
  logic                  zero_flag;

  // Operand words assembled least significant first
  assign value = {in_i.value_w3, in_i.value_w2, in_i.value_w1, in_i.value_w0};

  ami_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ami_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .value_i     (value),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .result_o    (result),
    .exponent_o  (exponent),
    .zero_o      (zero_flag)
  );

  // Result beat payload
  assign out_o.inverse_w0      = result[0*WORD_W +: WORD_W];
  assign out_o.inverse_w1      = result[1*WORD_W +: WORD_W];
  assign out_o.inverse_w2      = result[2*WORD_W +: WORD_W];
  assign out_o.inverse_w3      = result[3*WORD_W +: WORD_W];
  assign out_o.almost_exponent = exponent;
  assign out_o.zero_operand    = zero_flag;

endmodule

`default_nettype wire
